>>> hdl/irregular_series_lagged_cross_sum_defines.svh
// Assertion macros used by the checker of the lagged cross sum block.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef IRREGULAR_SERIES_LAGGED_CROSS_SUM_DEFINES_SVH
`define IRREGULAR_SERIES_LAGGED_CROSS_SUM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ISCS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/iscs_pkg.sv
// Package of the lagged cross sum block: sizes, command codes and control structs.
// Used by every module of the block but the RAM; depends on nothing.
package iscs_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int TIME_W      = 48;
	localparam int VAL_W       = 16;
	localparam int LAG_W       = 16;
	localparam int FRAC_W      = 16;
	localparam int SUM_W       = 64;
	localparam int PROD_W      = 2 * VAL_W;
	localparam int ENT_W       = TIME_W + VAL_W;
	// Shifted times: 48-bit unsigned time plus a signed lag of up to 2^31 needs 50 bits.
	localparam int BND_W       = TIME_W + 2;

	typedef enum logic [1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_APPEND_A = 2'd1,
		CMD_APPEND_B = 2'd2,
		CMD_COMPUTE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic load_shift;
		logic load_a;
		logic clr_sum;
		logic load_prod;
		logic acc;
		logic sel_end;
	} unit_ctl_t;

	typedef struct packed {
		logic             a_we;
		logic             b_we;
		logic [IDX_W-1:0] wr_addr;
		logic [IDX_W-1:0] a_rd_addr;
		logic [IDX_W-1:0] b_rd_addr;
	} mem_ctl_t;

endpackage

>>> hdl/iscs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module iscs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/iscs_unit.sv
// Shared arithmetic unit: interval bounds, time compare, product and accumulator.
// Depends on iscs_pkg.
module iscs_unit import iscs_pkg::*; (
	input  logic                    clk,
	input  unit_ctl_t               ctl,
	input  logic signed [LAG_W-1:0] lag,
	input  logic [ENT_W-1:0]        a_entry,
	input  logic [ENT_W-1:0]        b_entry,
	output logic                    b_lt,
	output logic signed [SUM_W-1:0] sum
);

	logic signed [BND_W-1:0]  shift_q;
	logic signed [BND_W-1:0]  begin_q;
	logic signed [BND_W-1:0]  end_q;
	logic signed [VAL_W-1:0]  va_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum_q;

	logic signed [BND_W-1:0]  a_bound;
	logic signed [BND_W-1:0]  b_time;
	logic signed [VAL_W-1:0]  b_value;

	assign a_bound = $signed({{(BND_W-TIME_W){1'b0}}, a_entry[TIME_W-1:0]}) + shift_q;
	assign b_time  = $signed({{(BND_W-TIME_W){1'b0}}, b_entry[TIME_W-1:0]});
	assign b_value = $signed(b_entry[ENT_W-1:TIME_W]);
	assign b_lt    = b_time < (ctl.sel_end ? end_q : begin_q);
	assign sum     = sum_q;

	always_ff @(posedge clk) begin
		if (ctl.load_shift) begin
			shift_q <= $signed({{(BND_W-LAG_W-FRAC_W){lag[LAG_W-1]}}, lag, {FRAC_W{1'b0}}});
		end
		if (ctl.load_a) begin
			// The end of the previous interval is the start of the next one.
			begin_q <= end_q;
			end_q   <= a_bound;
			va_q    <= $signed(a_entry[ENT_W-1:TIME_W]);
		end
		if (ctl.load_prod) begin
			prod_q <= va_q * b_value;
		end
		if (ctl.clr_sum) begin
			sum_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= sum_q + $signed({{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
		end
	end

endmodule

>>> hdl/iscs_ctrl.sv
// Sequencer of the lagged cross sum block: sample counts, append writes and compute walk.
// Depends on iscs_pkg.
module iscs_ctrl import iscs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  cmd_t      cmd,
	input  logic      b_lt,
	input  logic      out_free,
	output logic      ready,
	output mem_ctl_t  mem,
	output unit_ctl_t ucl,
	output logic      res_load,
	output logic      dropped
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_A_RD  = 9'b000000010,
		ST_A_WT  = 9'b000000100,
		ST_SA_RD = 9'b000001000,
		ST_SA_WT = 9'b000010000,
		ST_SP_RD = 9'b000100000,
		ST_SP_WT = 9'b001000000,
		ST_ACC   = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] a_cnt_q, a_cnt_d;
	logic [CNT_W-1:0] b_cnt_q, b_cnt_d;
	logic             ovf_q, ovf_d;
	logic [CNT_W-1:0] ai_q, ai_d;
	logic [CNT_W-1:0] start_q, start_d;
	logic [CNT_W-1:0] stop_q, stop_d;
	logic [CNT_W-1:0] start_rw;
	logic             last_i;

	// Step the search start back by one sample, never below the first.
	assign start_rw = (start_q != '0) ? start_q - CNT_W'(1) : '0;
	assign last_i   = (ai_q + CNT_W'(1)) == a_cnt_q;

	always_comb begin
		state_d       = state_q;
		a_cnt_d       = a_cnt_q;
		b_cnt_d       = b_cnt_q;
		ovf_d         = ovf_q;
		ai_d          = ai_q;
		start_d       = start_q;
		stop_d        = stop_q;
		ucl           = '0;
		res_load      = 1'b0;
		mem.a_we      = 1'b0;
		mem.b_we      = 1'b0;
		mem.wr_addr   = '0;
		mem.a_rd_addr = ai_q[IDX_W-1:0];
		mem.b_rd_addr = start_q[IDX_W-1:0];
		if (state_q == ST_SP_RD || state_q == ST_SP_WT || state_q == ST_ACC) begin
			mem.b_rd_addr = stop_q[IDX_W-1:0];
		end

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (cmd)
						CMD_CLEAR: begin
							a_cnt_d = '0;
							b_cnt_d = '0;
							ovf_d   = 1'b0;
						end
						CMD_APPEND_A: begin
							if (a_cnt_q < CNT_W'(MAX_SAMPLES)) begin
								mem.a_we    = 1'b1;
								mem.wr_addr = a_cnt_q[IDX_W-1:0];
								a_cnt_d     = a_cnt_q + CNT_W'(1);
							end else begin
								ovf_d = 1'b1;
							end
						end
						CMD_APPEND_B: begin
							if (b_cnt_q < CNT_W'(MAX_SAMPLES)) begin
								mem.b_we    = 1'b1;
								mem.wr_addr = b_cnt_q[IDX_W-1:0];
								b_cnt_d     = b_cnt_q + CNT_W'(1);
							end else begin
								ovf_d = 1'b1;
							end
						end
						CMD_COMPUTE: begin
							ucl.load_shift = 1'b1;
							ucl.clr_sum    = 1'b1;
							ai_d           = '0;
							start_d        = '0;
							if (a_cnt_q < CNT_W'(2) || b_cnt_q == '0) begin
								state_d = ST_FIN;
							end else begin
								state_d = ST_A_RD;
							end
						end
						default: ;
					endcase
				end
			end
			ST_A_RD: begin
				state_d = ST_A_WT;
			end
			ST_A_WT: begin
				ucl.load_a = 1'b1;
				if (ai_q == '0) begin
					ai_d    = CNT_W'(1);
					state_d = ST_A_RD;
				end else begin
					state_d = ST_SA_RD;
				end
			end
			ST_SA_RD: begin
				if (start_q == b_cnt_q) begin
					start_d = start_rw;
					stop_d  = start_rw;
					state_d = ST_SP_RD;
				end else begin
					state_d = ST_SA_WT;
				end
			end
			ST_SA_WT: begin
				if (b_lt) begin
					start_d = start_q + CNT_W'(1);
					state_d = ST_SA_RD;
				end else begin
					start_d = start_rw;
					stop_d  = start_rw;
					state_d = ST_SP_RD;
				end
			end
			ST_SP_RD: begin
				if (stop_q == b_cnt_q) begin
					if (last_i) begin
						state_d = ST_FIN;
					end else begin
						ai_d    = ai_q + CNT_W'(1);
						state_d = ST_A_RD;
					end
				end else begin
					state_d = ST_SP_WT;
				end
			end
			ST_SP_WT: begin
				ucl.sel_end = 1'b1;
				if (b_lt) begin
					ucl.load_prod = 1'b1;
					state_d       = ST_ACC;
				end else if (last_i) begin
					state_d = ST_FIN;
				end else begin
					ai_d    = ai_q + CNT_W'(1);
					state_d = ST_A_RD;
				end
			end
			ST_ACC: begin
				ucl.acc = 1'b1;
				stop_d  = stop_q + CNT_W'(1);
				state_d = ST_SP_RD;
			end
			ST_FIN: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			ovf_q   <= 1'b0;
			ai_q    <= '0;
			start_q <= '0;
			stop_q  <= '0;
		end else begin
			state_q <= state_d;
			a_cnt_q <= a_cnt_d;
			b_cnt_q <= b_cnt_d;
			ovf_q   <= ovf_d;
			ai_q    <= ai_d;
			start_q <= start_d;
			stop_q  <= stop_d;
		end
	end

	assign ready   = (state_q == ST_IDLE);
	assign dropped = ovf_q;

endmodule

>>> hdl/irregular_series_lagged_cross_sum.sv
// Lagged cross sum of two irregularly timed series: clear and append items stream back to
// back. A compute item walks the A intervals in order, searching B for each interval's
// start and summing its pairs; a short series (fewer than two A samples or no B samples)
// skips the walk and goes straight to the result.
// The walk is bounded by one read port per series RAM and the shared compare/multiply/
// accumulate unit. The result sits in an output register, so the next item is taken while it
// waits; a compute that finishes while that register is still full waits for it to drain.
// Reset (arst_n low, asynchronous) clears counts, drop flag, sequencer and output valid only.
module irregular_series_lagged_cross_sum import iscs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // sample_time [47:0], sample_value [63:48], lag [79:64]
	input  logic [1:0]  s_tuser,  // command [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // cross_sum [63:0]
	output logic [0:0]  m_tuser   // samples_dropped [0]
);

	// Input item fields.
	logic [TIME_W-1:0]       in_time;
	logic [VAL_W-1:0]        in_value;
	logic signed [LAG_W-1:0] in_lag;
	cmd_t                    in_cmd;
	logic                    in_fire;

	assign in_time  = s_tdata[TIME_W-1:0];
	assign in_value = s_tdata[ENT_W-1:TIME_W];
	assign in_lag   = $signed(s_tdata[ENT_W+LAG_W-1:ENT_W]);
	assign in_cmd   = cmd_t'(s_tuser);
	assign in_fire  = s_tvalid && s_tready;

	// Sequencer and shared unit.
	mem_ctl_t                mem;
	unit_ctl_t               ucl;
	logic                    b_lt;
	logic                    res_load;
	logic                    dropped;
	logic                    out_free;
	logic [ENT_W-1:0]        a_entry;
	logic [ENT_W-1:0]        b_entry;
	logic signed [SUM_W-1:0] sum;

	// Output register: loads when empty or when the waiting result is taken this cycle.
	logic              m_tvalid_q;
	logic [SUM_W-1:0]  m_sum_q;
	logic              m_drop_q;

	assign out_free = !m_tvalid_q || m_tready;

	iscs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.cmd      (in_cmd),
		.b_lt     (b_lt),
		.out_free (out_free),
		.ready    (s_tready),
		.mem      (mem),
		.ucl      (ucl),
		.res_load (res_load),
		.dropped  (dropped)
	);

	// Each RAM entry holds a sample as value in the upper bits and time in the lower bits.
	iscs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SAMPLES)) u_a_ram (
		.clk     (clk),
		.we      (mem.a_we),
		.wr_addr (mem.wr_addr),
		.wr_data ({in_value, in_time}),
		.rd_addr (mem.a_rd_addr),
		.rd_data (a_entry)
	);

	iscs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SAMPLES)) u_b_ram (
		.clk     (clk),
		.we      (mem.b_we),
		.wr_addr (mem.wr_addr),
		.wr_data ({in_value, in_time}),
		.rd_addr (mem.b_rd_addr),
		.rd_data (b_entry)
	);

	iscs_unit u_unit (
		.clk     (clk),
		.ctl     (ucl),
		.lag     (in_lag),
		.a_entry (a_entry),
		.b_entry (b_entry),
		.b_lt    (b_lt),
		.sum     (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_sum_q  <= sum;
			m_drop_q <= dropped;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_sum_q;
	assign m_tuser[0] = m_drop_q;

endmodule

>>> hdl/iscs_checker.sv
// Port-level checker for the lagged cross sum block, attached to the top level by bind.
// Depends on iscs_pkg and irregular_series_lagged_cross_sum_defines.svh.
`include "irregular_series_lagged_cross_sum_defines.svh"

module iscs_checker import iscs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [0:0]  m_tuser
);

	logic compute_fire;
	logic out_stall;

	assign compute_fire = s_tvalid && s_tready && (s_tuser == CMD_COMPUTE);
	assign out_stall    = m_tvalid && !m_tready;

	// A stalled result stays offered and unchanged.
	`ISCS_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid, "result withdrawn while stalled")
	`ISCS_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_tdata), "sum changed while stalled")
	`ISCS_ASSERT_NEXT(a_flag_stable, out_stall, $stable(m_tuser), "flag changed while stalled")

	// A compute item keeps the input side busy for at least the next cycle.
	`ISCS_ASSERT_NEXT(a_compute_busy, compute_fire, !s_tready, "input ready right after a compute item")

	// A new result appears only at the end of a compute walk, while the input side is busy.
	`ISCS_ASSERT_SAME(a_result_source, $rose(m_tvalid), !$past(s_tready), "result without a compute walk")

endmodule

bind irregular_series_lagged_cross_sum iscs_checker u_iscs_checker (.*);

>>> test/tb_irregular_series_lagged_cross_sum.sv
// Self-checking testbench for the lagged cross sum block: loads series A and B,
// computes at many lags and compares every cross sum with an internal predictor.
// Depends on iscs_pkg and the irregular_series_lagged_cross_sum module.
module tb_irregular_series_lagged_cross_sum import iscs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// A compute over the largest series used here accepts nothing on either side
	// while it runs, so the limit sits well above its length.
	localparam int WATCHDOG_LIMIT = 250000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PRESSURE_HOLD  = 300;
	localparam int MAX_PRINTS     = 20;
	localparam logic [47:0] TIME_MAX = {TIME_W{1'b1}};
	localparam int UNIT = 1 << FRAC_W;

	typedef struct {
		longint sum;
		bit     dropped;
	} cross_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic [1:0]  s_tuser = CMD_CLEAR;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [0:0]  m_tuser;

	// Predictor state: the two stored series, their fill levels and the drop flag.
	logic [TIME_W-1:0]       a_time [MAX_SAMPLES];
	logic signed [VAL_W-1:0] a_val  [MAX_SAMPLES];
	logic [TIME_W-1:0]       b_time [MAX_SAMPLES];
	logic signed [VAL_W-1:0] b_val  [MAX_SAMPLES];
	int                      a_len = 0;
	int                      b_len = 0;
	bit                      dropped = 1'b0;

	// Cross sums still owed by the block, oldest first.
	cross_result_t pending_sums [$];

	int  error_count     = 0;
	int  items_sent      = 0;
	int  computes_sent   = 0;
	int  results_checked = 0;
	int  drops_seen      = 0;
	int  quiet_cycles    = 0;
	int  hold_left       = 0;
	int  stall_left      = 0;
	bit  src_gaps        = 1'b1;
	bit  sink_gaps       = 1'b1;

	irregular_series_lagged_cross_sum uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Lagged cross sum over the stored series. Every A time is moved by the lag
	// in whole units; each A interval sums its end value against the B samples
	// that start before the interval end, beginning one sample before the first
	// B sample that is not earlier than the interval start. The B search start
	// only moves forward, apart from that one-step rewind.
	function automatic longint lagged_sum(logic signed [LAG_W-1:0] shift_units);
		longint total;
		longint offset;
		longint win_lo;
		longint win_hi;
		int     first;
		int     stop;
		total  = 0;
		first  = 0;
		offset = longint'(shift_units) * UNIT;
		for (int i = 1; i < a_len; i++) begin
			win_lo = longint'(a_time[i-1]) + offset;
			win_hi = longint'(a_time[i]) + offset;
			while (first < b_len && longint'(b_time[first]) < win_lo)
				first++;
			if (first > 0)
				first--;
			stop = first;
			while (stop < b_len && longint'(b_time[stop]) < win_hi)
				stop++;
			for (int j = first; j < stop; j++)
				total += longint'(a_val[i]) * longint'(b_val[j]);
		end
		return total;
	endfunction

	// Update the predicted series for one accepted item; a compute queues its sum.
	function automatic void apply_item(cmd_t op, logic [TIME_W-1:0] stamp,
			logic signed [VAL_W-1:0] level, logic signed [LAG_W-1:0] shift_units);
		cross_result_t res;
		case (op)
			CMD_CLEAR: begin
				a_len   = 0;
				b_len   = 0;
				dropped = 1'b0;
			end
			CMD_APPEND_A: begin
				if (a_len < MAX_SAMPLES) begin
					a_time[a_len] = stamp;
					a_val[a_len]  = level;
					a_len++;
				end else begin
					dropped = 1'b1;
				end
			end
			CMD_APPEND_B: begin
				if (b_len < MAX_SAMPLES) begin
					b_time[b_len] = stamp;
					b_val[b_len]  = level;
					b_len++;
				end else begin
					dropped = 1'b1;
				end
			end
			CMD_COMPUTE: begin
				res.sum     = lagged_sum(shift_units);
				res.dropped = dropped;
				pending_sums.push_back(res);
				computes_sent++;
			end
		endcase
	endfunction

	// Offer one item, starting and ending at a falling edge. The valid is only
	// lowered when a gap is inserted, so back-to-back items keep it high.
	task automatic send_item(cmd_t op, logic [TIME_W-1:0] stamp,
			logic signed [VAL_W-1:0] level, logic signed [LAG_W-1:0] shift_units);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {shift_units, level, stamp};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_item(op, stamp, level, shift_units);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic report_mismatch(string what, longint want, longint got);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("ERROR at %0t: %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	function automatic logic [TIME_W-1:0] rand_time();
		return TIME_W'({$urandom, $urandom});
	endfunction

	function automatic logic [15:0] rand16();
		return 16'($urandom);
	endfunction

	// Next time of a sorted run; it sticks at the top of the range instead of wrapping.
	function automatic logic [TIME_W-1:0] advance(logic [TIME_W-1:0] stamp, int step);
		logic [TIME_W:0] next;
		next = {1'b0, stamp} + (TIME_W+1)'(step);
		return next[TIME_W] ? TIME_MAX : next[TIME_W-1:0];
	endfunction

	// Mostly a few units apart, sometimes equal times, sometimes sub-unit steps.
	function automatic int rand_step();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return $urandom_range(1, UNIT - 1);
			default: return $urandom_range(UNIT / 2, 3 * UNIT);
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// Small lags make the shifted intervals overlap B; the rest cover the full range.
	function automatic logic signed [LAG_W-1:0] pick_lag();
		case ($urandom_range(0, 11))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			2, 3:    return LAG_W'($urandom);
			default: return LAG_W'(int'($urandom_range(0, 12)) - 6);
		endcase
	endfunction

	task automatic append_sorted(cmd_t op, int count, inout logic [TIME_W-1:0] stamp);
		for (int k = 0; k < count; k++) begin
			stamp = advance(stamp, rand_step());
			send_item(op, stamp, pick_value(), rand16());
		end
	endtask

	// Empty and one-sample series must give a zero sum, then one B sample gives a single pair; the drop flag stays low.
	task automatic test_short_series();
		send_item(CMD_CLEAR, rand_time(), rand16(), rand16());
		send_item(CMD_COMPUTE, rand_time(), rand16(), 16'sd0);
		send_item(CMD_APPEND_A, TIME_W'(5 * UNIT), 16'sd1000, rand16());
		send_item(CMD_APPEND_B, TIME_W'(6 * UNIT), 16'sd2000, rand16());
		send_item(CMD_COMPUTE, rand_time(), rand16(), 16'sd0);
		send_item(CMD_CLEAR, rand_time(), rand16(), rand16());
		send_item(CMD_APPEND_A, TIME_W'(1 * UNIT), 16'sd300, rand16());
		send_item(CMD_APPEND_A, TIME_W'(4 * UNIT), -16'sd700, rand16());
		send_item(CMD_COMPUTE, rand_time(), rand16(), 16'sd0);
		send_item(CMD_APPEND_B, TIME_W'(2 * UNIT), 16'sd900, rand16());
		send_item(CMD_COMPUTE, rand_time(), rand16(), -16'sd1);
	endtask

	// Times at both ends of the range, full-scale values and the extreme lags.
	task automatic test_extremes();
		send_item(CMD_CLEAR, rand_time(), rand16(), rand16());
		send_item(CMD_APPEND_A, 48'd0, 16'sh8000, rand16());
		send_item(CMD_APPEND_A, TIME_MAX, 16'sh7FFF, rand16());
		send_item(CMD_APPEND_B, 48'd0, 16'sh7FFF, rand16());
		send_item(CMD_APPEND_B, TIME_W'(1 * UNIT), 16'sh8000, rand16());
		send_item(CMD_APPEND_B, TIME_MAX, -16'sd1, rand16());
		send_item(CMD_COMPUTE, TIME_MAX, 16'sh8000, 16'sd0);
		send_item(CMD_COMPUTE, 48'd0, 16'sh7FFF, 16'sh8000);
		send_item(CMD_COMPUTE, rand_time(), rand16(), 16'sh7FFF);
	endtask

	// Decreasing and repeated times are stored as they come and searched in that order.
	task automatic test_unordered();
		send_item(CMD_CLEAR, rand_time(), rand16(), rand16());
		send_item(CMD_APPEND_A, TIME_W'(9 * UNIT), 16'sd1200, rand16());
		send_item(CMD_APPEND_A, TIME_W'(3 * UNIT), -16'sd800, rand16());
		send_item(CMD_APPEND_A, TIME_W'(7 * UNIT), 16'sd500, rand16());
		send_item(CMD_APPEND_B, TIME_W'(4 * UNIT), 16'sd2500, rand16());
		send_item(CMD_APPEND_B, TIME_W'(4 * UNIT), -16'sd1500, rand16());
		send_item(CMD_APPEND_B, TIME_W'(1 * UNIT), 16'sd700, rand16());
		send_item(CMD_COMPUTE, rand_time(), rand16(), 16'sd0);
		send_item(CMD_COMPUTE, rand_time(), rand16(), -16'sd3);
	endtask

	// Fill each series past capacity in turn: the extra appends are dropped and the
	// flag is reported until the next clear.
	task automatic test_full_series();
		logic [TIME_W-1:0] stamp;
		send_item(CMD_CLEAR, rand_time(), rand16(), rand16());
		stamp = 48'd0;
		append_sorted(CMD_APPEND_A, MAX_SAMPLES + 2, stamp);
		stamp = 48'd0;
		append_sorted(CMD_APPEND_B, 40, stamp);
		send_item(CMD_COMPUTE, rand_time(), rand16(), 16'sd0);
		send_item(CMD_COMPUTE, rand_time(), rand16(), 16'sd2);
		send_item(CMD_CLEAR, rand_time(), rand16(), rand16());
		send_item(CMD_COMPUTE, rand_time(), rand16(), 16'sd0);
		send_item(CMD_APPEND_A, 48'd0, 16'sh7FFF, rand16());
		send_item(CMD_APPEND_A, TIME_MAX, 16'sh8000, rand16());
		stamp = TIME_W'(1000 * UNIT);
		append_sorted(CMD_APPEND_B, MAX_SAMPLES + 1, stamp);
		send_item(CMD_COMPUTE, rand_time(), rand16(), 16'sd0);
		send_item(CMD_COMPUTE, rand_time(), rand16(), -16'sd100);
	endtask

	// The receiver holds off for a long stretch while items keep coming, so the
	// output register fills and the next compute has to wait at the input.
	task automatic test_backpressure();
		logic [TIME_W-1:0] ta;
		logic [TIME_W-1:0] tb_stamp;
		send_item(CMD_CLEAR, rand_time(), rand16(), rand16());
		ta       = TIME_W'(20 * UNIT);
		tb_stamp = TIME_W'(20 * UNIT);
		append_sorted(CMD_APPEND_A, 6, ta);
		append_sorted(CMD_APPEND_B, 6, tb_stamp);
		hold_left = PRESSURE_HOLD;
		send_item(CMD_COMPUTE, rand_time(), rand16(), 16'sd0);
		append_sorted(CMD_APPEND_A, 3, ta);
		send_item(CMD_COMPUTE, rand_time(), rand16(), 16'sd1);
		append_sorted(CMD_APPEND_B, 3, tb_stamp);
		send_item(CMD_COMPUTE, rand_time(), rand16(), -16'sd1);
		send_item(CMD_COMPUTE, rand_time(), rand16(), 16'sd0);
	endtask

	// Random traffic in episodes. Most are well-formed: an optional clear, sorted A
	// and B runs from a shared base, interleaved, then a few computes. About one in
	// six is noise: random commands with random or clustered times. Series are
	// cleared before they grow large so that one compute stays short.
	task automatic test_random(int count, bit with_gaps);
		int                stop_at;
		int                na;
		int                nb;
		logic [TIME_W-1:0] ta;
		logic [TIME_W-1:0] tb_stamp;
		logic [TIME_W-1:0] base;
		cmd_t              op;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			src_gaps  = with_gaps && $urandom_range(0, 3) != 0;
			sink_gaps = with_gaps && $urandom_range(0, 3) != 0;
			base = rand_time();
			if ($urandom_range(0, 3) == 0)
				base = base >> $urandom_range(1, 47);
			if (a_len + b_len > 80 || $urandom_range(0, 4) != 0)
				send_item(CMD_CLEAR, rand_time(), rand16(), rand16());
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(4, 16)) begin
					op = cmd_t'($urandom_range(0, 3));
					send_item(op, $urandom_range(0, 1) ? rand_time() :
						advance(base, $urandom_range(0, 8 * UNIT)), rand16(), rand16());
				end
			end else begin
				na = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
				nb = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
				ta       = base;
				tb_stamp = advance(base, $urandom_range(0, 2 * UNIT));
				while (na > 0 || nb > 0) begin
					if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 1)) begin
						append_sorted(CMD_APPEND_A, 1, ta);
						na--;
					end else begin
						append_sorted(CMD_APPEND_B, 1, tb_stamp);
						nb--;
					end
				end
				repeat ($urandom_range(1, 4))
					send_item(CMD_COMPUTE, rand_time(), rand16(), pick_lag());
			end
		end
	endtask

	// Receiver: a long hold requested by a test wins, then random stall bursts.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(1, 9) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Each accepted cross sum is matched against the oldest expectation.
	always @(posedge clk) begin : check_results
		cross_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sums.size() == 0) begin
				report_mismatch("cross sum with nothing expected", 64'sd0, $signed(m_tdata));
			end else begin
				want = pending_sums.pop_front();
				results_checked++;
				if (want.dropped)
					drops_seen++;
				if (m_tdata !== want.sum)
					report_mismatch("cross_sum", want.sum, $signed(m_tdata));
				if (m_tuser[0] !== want.dropped)
					report_mismatch("samples_dropped", longint'(want.dropped),
						longint'(m_tuser[0]));
			end
		end
	end

	// Ends the run if neither side moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles, %0d cross sums outstanding",
				quiet_cycles, pending_sums.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_short_series();
		test_extremes();
		test_unordered();
		test_full_series();
		test_backpressure();
		test_random(150, 1'b1);
		test_random(60, 1'b0);

		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		s_tvalid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items including %0d computes; checked %0d cross sums, %0d with drops.",
			items_sent, computes_sent, results_checked, drops_seen);
		$display("Covered empty, short, unordered and overfull series, extreme lags and a long hold.");
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/iscs_pkg.sv
hdl/iscs_ram.sv
hdl/iscs_unit.sv
hdl/iscs_ctrl.sv
hdl/irregular_series_lagged_cross_sum.sv
hdl/iscs_checker.sv
test/tb_irregular_series_lagged_cross_sum.sv
